// ===== src/esl_pkg.sv =====
`default_nettype none

package esl_pkg;

   // Request commands.
   typedef enum logic [1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_CLEAR  = 2'd1,
      CMD_SET    = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   // Configuration register indexes.
   localparam logic [1:0] REG_BUTTON_INVERTED = 2'd0;
   localparam logic [1:0] REG_HOLD_MS         = 2'd1;
   localparam logic [1:0] REG_LATCHING_MODE   = 2'd2;
   localparam logic [1:0] REG_MIN_PRESS_MS    = 2'd3;

   // Configuration reset values and the floor on the minimum press time.
   localparam logic [15:0] HOLD_MS_RESET      = 16'd30;
   localparam logic [31:0] MIN_PRESS_RESET    = 32'd500;
   localparam logic [31:0] MIN_PRESS_FLOOR    = 32'd100;

   // Release sequence marks.
   localparam logic [3:0] MARK_FIRST_PRESS = 4'h1;
   localparam logic [3:0] MARK_LONG_PRESS  = 4'h2;
   localparam logic [3:0] MARK_FIRST_REL   = 4'h4;
   localparam logic [3:0] MARK_SECOND_REL  = 4'h8;
   localparam logic [3:0] MARK_ALL         = 4'hF;

   typedef struct packed {
      cmd_type     cmd;
      logic        pin_level;
      logic [31:0] now_ms;
      logic        request_value;
   } req_type;

   typedef struct packed {
      logic stop_active;
      logic button_pressed;
   } rsp_type;

   typedef struct packed {
      logic        button_inverted;
      logic [15:0] hold_ms;
      logic        latching_mode;
      logic [31:0] min_press_ms;
   } cfg_type;

endpackage

`default_nettype wire

// ===== src/esl_csr.sv =====
`default_nettype none

module esl_csr
   import esl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   output cfg_type          cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // The register file never blocks a write.
   assign csr_ready = 1'b1;

   // Decode the write; the minimum press time is clamped to its floor.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_BUTTON_INVERTED: cfg_in.button_inverted = csr_wdata[0];
            REG_HOLD_MS:         cfg_in.hold_ms = csr_wdata[15:0];
            REG_LATCHING_MODE:   cfg_in.latching_mode = csr_wdata[0];
            REG_MIN_PRESS_MS: begin
               cfg_in.min_press_ms = (csr_wdata < MIN_PRESS_FLOOR) ?
                                     MIN_PRESS_FLOOR : csr_wdata;
            end
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.button_inverted <= 1'b0;
         cfg_ff.hold_ms         <= HOLD_MS_RESET;
         cfg_ff.latching_mode   <= 1'b0;
         cfg_ff.min_press_ms    <= MIN_PRESS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

   // The stored minimum press time never drops below the floor.
   assert property (@(posedge clock) disable iff (reset)
      cfg_ff.min_press_ms >= MIN_PRESS_FLOOR)
      else $error("minimum press time below floor");

endmodule

`default_nettype wire

// ===== src/esl_stop.sv =====
`default_nettype none

module esl_stop
   import esl_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire req_type req,
   input  wire logic    commit,
   output rsp_type      rsp
);

   logic        button_ff,  button_in;
   logic [31:0] deb_start_ff, deb_start_in;
   logic        stop_ff,    stop_in;
   logic [3:0]  marks_ff,   marks_in;
   logic [31:0] press_ff,   press_in;
   logic        pending_ff, pending_in;

   // Next state for the request held in the input register.
   always_comb begin
      logic target;
      logic [31:0] deb_age;
      logic [31:0] press_age;

      button_in    = button_ff;
      deb_start_in = deb_start_ff;
      stop_in      = stop_ff;
      marks_in     = marks_ff;
      press_in     = press_ff;
      pending_in   = pending_ff;
      target       = req.pin_level ^ cfg.button_inverted;
      deb_age      = req.now_ms - deb_start_ff;
      press_age    = 32'd0;

      case (req.cmd)
         CMD_SAMPLE: begin
            // Debounce: restart the timer while the pin agrees.
            if (button_ff == target) begin
               deb_start_in = req.now_ms;
            end else if ({16'd0, cfg.hold_ms} <= deb_age) begin
               button_in = target;
            end

            if (!cfg.latching_mode) begin
               // Follow mode copies the button and drops the release sequence.
               stop_in  = button_in;
               marks_in = 4'd0;
               press_in = 32'd0;
            end else begin
               if (button_in || (pending_ff && !stop_ff)) begin
                  if (marks_in == 4'd0) begin
                     marks_in = MARK_FIRST_PRESS;
                     press_in = req.now_ms;
                     stop_in  = 1'b1;
                  end
                  press_age = req.now_ms - press_in;
                  if ((marks_in & (MARK_FIRST_PRESS | MARK_FIRST_REL)) ==
                      (MARK_FIRST_PRESS | MARK_FIRST_REL) &&
                      press_age >= cfg.min_press_ms) begin
                     marks_in = marks_in | MARK_LONG_PRESS;
                  end
               end else begin
                  if (stop_in && (marks_in & MARK_FIRST_PRESS) != 4'd0) begin
                     marks_in = marks_in | MARK_FIRST_REL;
                  end
                  if (stop_in && (marks_in & MARK_LONG_PRESS) != 4'd0) begin
                     marks_in = marks_in | MARK_SECOND_REL;
                  end
                  if ((marks_in & MARK_ALL) == MARK_ALL) begin
                     marks_in = 4'd0;
                     press_in = 32'd0;
                     stop_in  = 1'b0;
                  end
               end
               pending_in = 1'b0;
            end
         end
         CMD_CLEAR: begin
            // Clear acts only in latching mode with the button up.
            if (cfg.latching_mode && !button_ff) begin
               marks_in = 4'd0;
               press_in = 32'd0;
               stop_in  = 1'b0;
            end
         end
         CMD_SET: begin
            // A software request is stored only in latching mode while no stop is active.
            if (cfg.latching_mode && !stop_ff) begin
               pending_in = req.request_value;
            end
         end
         default: begin
            button_in = button_ff;
         end
      endcase
   end

   // State advances only when the request moves into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         button_ff    <= 1'b0;
         deb_start_ff <= 32'd0;
         stop_ff      <= 1'b0;
         marks_ff     <= 4'd0;
         press_ff     <= 32'd0;
         pending_ff   <= 1'b0;
      end else if (commit) begin
         button_ff    <= button_in;
         deb_start_ff <= deb_start_in;
         stop_ff      <= stop_in;
         marks_ff     <= marks_in;
         press_ff     <= press_in;
         pending_ff   <= pending_in;
      end
   end

   assign rsp.stop_active    = stop_in;
   assign rsp.button_pressed = button_in;

   // A completed release sequence is cleared at once, so the last mark never persists.
   assert property (@(posedge clock) disable iff (reset)
      marks_ff[3] == 1'b0)
      else $error("second release mark stored");

   // A long press is only recognized after a first press and release.
   assert property (@(posedge clock) disable iff (reset)
      marks_ff[1] |-> (marks_ff[0] && marks_ff[2]))
      else $error("long press mark out of order");

   // Follow mode leaves no release sequence behind.
   assert property (@(posedge clock) disable iff (reset)
      (commit && req.cmd == CMD_SAMPLE && !cfg.latching_mode) |=>
      (marks_ff == 4'd0 && press_ff == 32'd0))
      else $error("release sequence kept in follow mode");

   // Only a sample request can raise the stop.
   assert property (@(posedge clock) disable iff (reset)
      (commit && req.cmd != CMD_SAMPLE && !stop_ff) |=> !stop_ff)
      else $error("stop raised by a non-sample request");

endmodule

`default_nettype wire

// ===== src/debounced_emergency_stop_latch_core.sv =====
// Debounced emergency-stop latch.
//
// Requests arrive on the req_ channel (valid/stall): a sample tick with the
// raw pin level and a millisecond timestamp, a clear request or a software
// stop request. Every request gives exactly one response on the rsp_ channel
// with the stop state and the debounced button state after that request.
// The csr_ port (valid/ready, always ready) writes the button polarity,
// debounce hold time, latching mode and minimum press time; the user must
// write it only while no request is in flight; the block does not enforce it.
//
// Each accepted request is registered in the input register and its response
// in the response register, and one request is accepted every cycle while
// the receiver does not stall. The debounce and latch update is one pass of
// logic between the input register and the response register.
// When the receiver stalls, the response register holds its payload, the
// input register keeps its request and req_stall rises once both are full.
// Reset clears both pipeline stages and all latch state and loads the
// register defaults: normal polarity, 30 ms hold, follow mode, 500 ms.
`default_nettype none

module debounced_emergency_stop_latch_core
   import esl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_payload,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   cfg_type cfg;
   logic    in_valid_ff, in_valid_in;
   req_type in_req_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_rsp_ff;
   rsp_type step_rsp;
   logic    advance;
   logic    req_accept;

   esl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   esl_stop u_stop (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req    (in_req_ff),
      .commit (advance),
      .rsp    (step_rsp)
   );

   // Pipeline control: the input stage moves on when the response slot is free.
   assign advance    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_req_ff <= req_payload;
      end
      if (advance) begin
         out_rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_rsp_ff;

endmodule

`default_nettype wire

// ===== tb/tb_debounced_emergency_stop_latch_core.sv =====
`timescale 1ns / 100ps

module tb_debounced_emergency_stop_latch_core;
   import esl_pkg::*;

   localparam int RAND_PHASES      = 10;
   localparam int ITEMS_PER_PHASE  = 75;
   localparam int PRESSURE_PHASE   = 3;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT      = 2000;
   localparam int END_SETTLE       = 10;

   // One row of the directed sequence: a register write or a request.
   typedef struct {
      logic        is_reg;
      logic [1:0]  reg_idx;
      logic [31:0] reg_val;
      req_type     item;
      logic        typed;
      rsp_type     want;
   } step_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   debounced_emergency_stop_latch_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // Shadow copy of the block's configuration and latch state.
   cfg_type     est_cfg;
   logic        est_button;
   logic [31:0] est_db_start;
   logic        est_stop;
   logic [3:0]  est_marks;
   logic [31:0] est_press_t;
   logic        est_pending;

   rsp_type     stop_reports[$];
   int          sent_count = 0;
   int          rcvd_count = 0;
   int          error_count = 0;
   int          burst_left = 0;
   logic        gaps_on = 1'b0;
   int          stall_pct = 0;
   logic        long_hold_req = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Debounce the pin and update the stop state for a sample tick; apply clear and set requests.
   function automatic rsp_type advance_estop(input req_type r);
      logic        target;
      logic [31:0] elapsed;
      rsp_type     o;
      case (r.cmd)
         CMD_SAMPLE: begin
            target = r.pin_level ^ est_cfg.button_inverted;
            elapsed = r.now_ms - est_db_start;
            if (est_button == target) begin
               est_db_start = r.now_ms;
            end else if (elapsed >= {16'd0, est_cfg.hold_ms}) begin
               est_button = target;
            end
            if (!est_cfg.latching_mode) begin
               // Follow mode keeps any pending software request.
               est_stop = est_button;
               est_marks = '0;
               est_press_t = '0;
            end else begin
               if (est_button || (est_pending && !est_stop)) begin
                  if (est_marks == '0) begin
                     est_marks = MARK_FIRST_PRESS;
                     est_press_t = r.now_ms;
                     est_stop = 1'b1;
                  end
                  elapsed = r.now_ms - est_press_t;
                  if ((est_marks & (MARK_FIRST_PRESS | MARK_FIRST_REL)) ==
                      (MARK_FIRST_PRESS | MARK_FIRST_REL) &&
                      elapsed >= est_cfg.min_press_ms) begin
                     est_marks = est_marks | MARK_LONG_PRESS;
                  end
               end else begin
                  if (est_stop && (est_marks & MARK_FIRST_PRESS) != '0) begin
                     est_marks = est_marks | MARK_FIRST_REL;
                  end
                  if (est_stop && (est_marks & MARK_LONG_PRESS) != '0) begin
                     est_marks = est_marks | MARK_SECOND_REL;
                  end
                  if (est_marks == MARK_ALL) begin
                     est_marks = '0;
                     est_press_t = '0;
                     est_stop = 1'b0;
                  end
               end
               // Every latching tick drops the software request.
               est_pending = 1'b0;
            end
         end
         CMD_CLEAR: begin
            if (est_cfg.latching_mode && !est_button) begin
               est_marks = '0;
               est_press_t = '0;
               est_stop = 1'b0;
            end
         end
         CMD_SET: begin
            if (est_cfg.latching_mode && !est_stop) begin
               est_pending = r.request_value;
            end
         end
         default: begin
         end
      endcase
      o.stop_active = est_stop;
      o.button_pressed = est_button;
      return o;
   endfunction

   function automatic step_row_type row_req(input cmd_type c, input logic pin,
                                            input logic [31:0] t, input logic rv,
                                            input logic typed, input logic st,
                                            input logic bt);
      step_row_type row;
      row.is_reg = 1'b0;
      row.reg_idx = '0;
      row.reg_val = '0;
      row.item.cmd = c;
      row.item.pin_level = pin;
      row.item.now_ms = t;
      row.item.request_value = rv;
      row.typed = typed;
      row.want.stop_active = st;
      row.want.button_pressed = bt;
      return row;
   endfunction

   function automatic step_row_type row_reg(input logic [1:0] idx, input logic [31:0] val);
      step_row_type row;
      row = row_req(CMD_SAMPLE, 1'b0, '0, 1'b0, 1'b0, 1'b0, 1'b0);
      row.is_reg = 1'b1;
      row.reg_idx = idx;
      row.reg_val = val;
      return row;
   endfunction

   // Offer one request, wait for it to be taken and queue its expected report.
   task automatic offer_request(input req_type r, input logic typed, input rsp_type want);
      rsp_type got;
      csr_valid <= 1'b0;
      req_payload <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
      got = advance_estop(r);
      stop_reports.push_back(typed ? want : got);
      // Sender works in bursts separated by idle gaps.
      if (gaps_on) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            burst_left = $urandom_range(1, 25);
         end else begin
            burst_left--;
         end
      end
   endtask

   // Stop offering and wait until every report has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (rcvd_count < sent_count) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_BUTTON_INVERTED: est_cfg.button_inverted = val[0];
         REG_HOLD_MS:         est_cfg.hold_ms = val[15:0];
         REG_LATCHING_MODE:   est_cfg.latching_mode = val[0];
         default:             est_cfg.min_press_ms = (val >= MIN_PRESS_FLOOR) ? val
                                                                            : MIN_PRESS_FLOOR;
      endcase
   endtask

   // Receiver stall pattern, with one long hold-off on request.
   initial begin : rsp_stall_gen
      int   run_left;
      logic stalled;
      run_left = 0;
      stalled = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            run_left = 0;
         end else begin
            if (run_left == 0) begin
               stalled = ($urandom_range(0, 99) < stall_pct);
               run_left = $urandom_range(1, 8);
            end
            run_left--;
            rsp_stall <= stalled;
         end
      end
   end

   // Compare each report with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rcvd_count++;
         if (stop_reports.size() == 0) begin
            $display("%0t: unexpected report stop=%b button=%b", $time,
                     rsp_payload.stop_active, rsp_payload.button_pressed);
            error_count++;
         end else begin
            want = stop_reports.pop_front();
            if (rsp_payload.stop_active !== want.stop_active) begin
               $display("%0t: stop_active expected %b actual %b", $time,
                        want.stop_active, rsp_payload.stop_active);
               error_count++;
            end
            if (rsp_payload.button_pressed !== want.button_pressed) begin
               $display("%0t: button_pressed expected %b actual %b", $time,
                        want.button_pressed, rsp_payload.button_pressed);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles where no handshake completes.
   always @(posedge clock) begin
      int quiet_cycles;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin : stimulus
      step_row_type dir_rows[$];
      req_type     item;
      rsp_type     none;
      logic [31:0] now_t;
      logic [31:0] mp_val;
      logic [15:0] hv;
      logic        pin_now;
      int          pin_run;
      int          step_max;
      int          roll;

      est_cfg.button_inverted = 1'b0;
      est_cfg.hold_ms = HOLD_MS_RESET;
      est_cfg.latching_mode = 1'b0;
      est_cfg.min_press_ms = MIN_PRESS_RESET;
      est_button = 1'b0;
      est_db_start = '0;
      est_stop = 1'b0;
      est_marks = '0;
      est_press_t = '0;
      est_pending = 1'b0;
      none = '0;

      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Follow mode at reset defaults, including hold across the time wrap.
      dir_rows.push_back(row_req(CMD_SAMPLE, 1'b0, 32'd0, 1'b0, 1'b1, 1'b0, 1'b0));
      dir_rows.push_back(row_req(CMD_SAMPLE, 1'b1, 32'd10, 1'b0, 1'b1, 1'b0, 1'b0));
      dir_rows.push_back(row_req(CMD_SAMPLE, 1'b1, 32'd40, 1'b0, 1'b1, 1'b1, 1'b1));
      dir_rows.push_back(row_req(CMD_UNUSED, 1'b0, 32'd0, 1'b1, 1'b1, 1'b1, 1'b1));
      dir_rows.push_back(row_req(CMD_CLEAR, 1'b0, 32'd50, 1'b0, 1'b1, 1'b1, 1'b1));
      dir_rows.push_back(row_req(CMD_SET, 1'b0, 32'd50, 1'b1, 1'b1, 1'b1, 1'b1));
      dir_rows.push_back(row_req(CMD_SAMPLE, 1'b1, 32'hFFFF_FFF0, 1'b0, 1'b1, 1'b1, 1'b1));
      dir_rows.push_back(row_req(CMD_SAMPLE, 1'b0, 32'h0000_000D, 1'b0, 1'b0, 1'b0, 1'b0));
      dir_rows.push_back(row_req(CMD_SAMPLE, 1'b0, 32'h0000_000E, 1'b0, 1'b0, 1'b0, 1'b0));
      // Latching mode with no hold: full press-release cycle, software request,
      // clear with the button up and down. A write below the floor clamps.
      dir_rows.push_back(row_reg(REG_HOLD_MS, 32'd0));
      dir_rows.push_back(row_reg(REG_LATCHING_MODE, 32'd1));
      dir_rows.push_back(row_reg(REG_MIN_PRESS_MS, 32'd5));
      dir_rows.push_back(row_req(CMD_SAMPLE, 1'b1, 32'd1000, 1'b0, 1'b1, 1'b1, 1'b1));
      dir_rows.push_back(row_req(CMD_SAMPLE, 1'b0, 32'd1010, 1'b0, 1'b1, 1'b1, 1'b0));
      dir_rows.push_back(row_req(CMD_SAMPLE, 1'b1, 32'd1050, 1'b0, 1'b1, 1'b1, 1'b1));
      dir_rows.push_back(row_req(CMD_SAMPLE, 1'b1, 32'd1100, 1'b0, 1'b1, 1'b1, 1'b1));
      dir_rows.push_back(row_req(CMD_SAMPLE, 1'b0, 32'd1110, 1'b0, 1'b1, 1'b0, 1'b0));
      dir_rows.push_back(row_req(CMD_SET, 1'b0, 32'd1150, 1'b1, 1'b1, 1'b0, 1'b0));
      dir_rows.push_back(row_req(CMD_SAMPLE, 1'b0, 32'd1200, 1'b0, 1'b1, 1'b1, 1'b0));
      dir_rows.push_back(row_req(CMD_SET, 1'b0, 32'd1210, 1'b1, 1'b1, 1'b1, 1'b0));
      dir_rows.push_back(row_req(CMD_CLEAR, 1'b0, 32'd1220, 1'b0, 1'b1, 1'b0, 1'b0));
      dir_rows.push_back(row_req(CMD_SAMPLE, 1'b1, 32'd1300, 1'b0, 1'b1, 1'b1, 1'b1));
      dir_rows.push_back(row_req(CMD_CLEAR, 1'b1, 32'd1310, 1'b0, 1'b1, 1'b1, 1'b1));
      dir_rows.push_back(row_req(CMD_SET, 1'b0, 32'd1320, 1'b0, 1'b1, 1'b1, 1'b1));
      // Inverted polarity with the largest hold and minimum press.
      dir_rows.push_back(row_reg(REG_BUTTON_INVERTED, 32'd1));
      dir_rows.push_back(row_reg(REG_HOLD_MS, 32'h0000_FFFF));
      dir_rows.push_back(row_reg(REG_MIN_PRESS_MS, 32'hFFFF_FFFF));
      dir_rows.push_back(row_req(CMD_SAMPLE, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0));
      dir_rows.push_back(row_req(CMD_SAMPLE, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0));
      dir_rows.push_back(row_req(CMD_CLEAR, 1'b1, 32'h5555_AAAA, 1'b1, 1'b0, 1'b0, 1'b0));
      dir_rows.push_back(row_req(CMD_UNUSED, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0));

      gaps_on = 1'b1;
      stall_pct = 25;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_reg) begin
            wait_idle();
            write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
         end else begin
            offer_request(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
         end
      end

      // Random phases: mostly plausible button activity on an advancing clock.
      now_t = $urandom_range(0, 5000);
      pin_now = 1'b0;
      pin_run = 0;
      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         wait_idle();
         write_reg(REG_BUTTON_INVERTED, $urandom_range(0, 1));
         case ($urandom_range(0, 3))
            0:       hv = 16'd0;
            1:       hv = 16'hFFFF;
            2:       hv = 16'($urandom_range(1, 100));
            default: hv = HOLD_MS_RESET;
         endcase
         write_reg(REG_HOLD_MS, {16'd0, hv});
         write_reg(REG_LATCHING_MODE, ($urandom_range(0, 9) < 7) ? 32'd1 : 32'd0);
         case ($urandom_range(0, 3))
            0:       mp_val = $urandom_range(0, 99);
            1:       mp_val = MIN_PRESS_FLOOR;
            2:       mp_val = 32'hFFFF_FFFF;
            default: mp_val = $urandom_range(100, 2000);
         endcase
         write_reg(REG_MIN_PRESS_MS, mp_val);

         if (phase == 0) begin
            gaps_on = 1'b0;
            stall_pct = 0;
         end else begin
            gaps_on = $urandom_range(0, 3) != 0;
            case ($urandom_range(0, 2))
               0:       stall_pct = 0;
               1:       stall_pct = 25;
               default: stall_pct = 60;
            endcase
         end
         if (phase == PRESSURE_PHASE) begin
            gaps_on = 1'b0;
            long_hold_req = 1'b1;
         end

         // Sometimes start just short of the wrap so it falls inside the phase.
         if ($urandom_range(0, 2) == 0) begin
            now_t = 32'hFFFF_FFFF - $urandom_range(0, 20000);
         end
         step_max = (est_cfg.hold_ms >> 2) + 8 +
                    ((est_cfg.min_press_ms > 4000) ? 250 : est_cfg.min_press_ms / 16);

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            roll = $urandom_range(0, 99);
            item.cmd = CMD_SAMPLE;
            item.pin_level = pin_now;
            item.now_ms = now_t;
            item.request_value = 1'($urandom_range(0, 1));
            if (roll < 8) begin
               // Noise: anything at any time.
               item.cmd = cmd_type'($urandom_range(0, 3));
               item.pin_level = 1'($urandom_range(0, 1));
               item.now_ms = $urandom;
            end else if (roll < 16) begin
               item.cmd = CMD_CLEAR;
            end else if (roll < 24) begin
               item.cmd = CMD_SET;
            end else if (roll < 27) begin
               item.cmd = CMD_UNUSED;
            end else begin
               now_t = now_t + $urandom_range(0, step_max);
               item.now_ms = now_t;
               if (pin_run == 0) begin
                  pin_now = ~pin_now;
                  pin_run = $urandom_range(1, 30);
               end else begin
                  pin_run--;
               end
               // Occasional single-sample bounce.
               item.pin_level = ($urandom_range(0, 9) == 0) ? ~pin_now : pin_now;
            end
            offer_request(item, 1'b0, none);
         end
      end

      wait_idle();
      repeat (END_SETTLE) @(posedge clock);
      if (error_count == 0 && stop_reports.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== debounced_emergency_stop_latch_core.f =====
src/esl_pkg.sv
src/esl_csr.sv
src/esl_stop.sv
src/debounced_emergency_stop_latch_core.sv
tb/tb_debounced_emergency_stop_latch_core.sv
